// ===== sv/opcode_pair_frequency_counter_core_assert.svh =====
// Assertion macros for the opcode pair frequency counter.
// Used by opfc_maxscan and the top-level core; no other dependencies.
`ifndef OPCODE_PAIR_FREQUENCY_COUNTER_CORE_ASSERT_SVH
`define OPCODE_PAIR_FREQUENCY_COUNTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define OPFC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define OPFC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define OPFC_ASSERT(lbl, clk, rstn, prop, msg)
`define OPFC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== sv/opfc_pkg.sv =====
// Shared constants and types of the opcode pair frequency counter.
// No dependencies; imported by opfc_maxscan and the top level.
`default_nettype none

package opfc_pkg;

  localparam int unsigned NUM_OPCODES_DEF = 128;
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned MAX_ROWS_DEF    = 64;

  // Fixed field widths of the stream payload
  localparam int unsigned OPCODE_W    = 7;
  localparam int unsigned ROWS_W      = 7;
  localparam int unsigned OUT_COUNT_W = 32;
  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned OUT_DATA_W  = 48;

  // Status of the max-search unit after a pass over the table
  typedef struct packed {
    logic found;   // at least one nonzero counter seen
    logic multi;   // at least two nonzero counters seen
  } opfc_scan_stat_t;

endpackage

`default_nettype wire

// ===== sv/opfc_table.sv =====
// Counter table: simple dual-port memory, one write and one registered read.
// No package dependencies.
`default_nettype none

module opfc_table #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/opfc_maxscan.sv =====
// Max-search unit: one compare per cycle over the streamed table entries while en_i is high.
// Depends on opfc_pkg and the assertion macro header.
`default_nettype none
`include "opcode_pair_frequency_counter_core_assert.svh"

module opfc_maxscan #(
  parameter int unsigned CW  = 32,
  parameter int unsigned OPW = 7,
  parameter int unsigned AW  = 14
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      en_i,
  input  logic [CW-1:0]             data_i,
  input  logic [OPW-1:0]            row_i,
  input  logic [OPW-1:0]            col_i,
  input  logic [AW-1:0]             addr_i,
  output logic [CW-1:0]             best_count_o,
  output logic [OPW-1:0]            best_row_o,
  output logic [OPW-1:0]            best_col_o,
  output logic [AW-1:0]             best_addr_o,
  output opfc_pkg::opfc_scan_stat_t stat_o
);
  import opfc_pkg::*;

  logic [CW-1:0]  best_count_q, best_count_d;
  logic [OPW-1:0] best_row_q, best_row_d;
  logic [OPW-1:0] best_col_q, best_col_d;
  logic [AW-1:0]  best_addr_q, best_addr_d;
  logic [1:0]     nz_cnt_q, nz_cnt_d;
  logic           greater;

  // strict compare: earliest index keeps ties
  assign greater = (data_i > best_count_q);

  always_comb begin
    best_count_d = best_count_q;
    best_row_d   = best_row_q;
    best_col_d   = best_col_q;
    best_addr_d  = best_addr_q;
    nz_cnt_d     = nz_cnt_q;
    if (start_i) begin
      best_count_d = '0;
      best_row_d   = '0;
      best_col_d   = '0;
      best_addr_d  = '0;
      nz_cnt_d     = '0;
    end else if (en_i) begin
      if (greater) begin
        best_count_d = data_i;
        best_row_d   = row_i;
        best_col_d   = col_i;
        best_addr_d  = addr_i;
      end
      if ((data_i != '0) && (nz_cnt_q != 2'd2)) begin
        nz_cnt_d = nz_cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_count_q <= '0;
      nz_cnt_q     <= '0;
    end else begin
      best_count_q <= best_count_d;
      nz_cnt_q     <= nz_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_row_q  <= best_row_d;
    best_col_q  <= best_col_d;
    best_addr_q <= best_addr_d;
  end

  assign best_count_o = best_count_q;
  assign best_row_o   = best_row_q;
  assign best_col_o   = best_col_q;
  assign best_addr_o  = best_addr_q;
  assign stat_o.found = (nz_cnt_q != 2'd0);
  assign stat_o.multi = (nz_cnt_q == 2'd2);

  `OPFC_ASSERT(a_found_matches_best, clk_i, rst_ni, stat_o.found == (best_count_q != '0), "found flag disagrees with best count")
  `OPFC_ASSERT_IMPLY(a_multi_implies_found, clk_i, rst_ni, stat_o.multi, stat_o.found, "multi set without found")
  `OPFC_ASSERT_IMPLY(a_start_clears, clk_i, rst_ni, start_i, ##1 (nz_cnt_q == 2'd0), "start did not clear the search")

endmodule

`default_nettype wire

// ===== sv/opcode_pair_frequency_counter_core.sv =====
// Log item: a counted pair is read in S_IDLE and written back in S_LOG_WR; else no write.
// Report item: each row takes a full one-entry-per-cycle scan of the counter memory through
//   the shared compare unit, then S_SCAN_END and S_EMIT, which waits on output stalls.
// Rows ready one at a time; the input is taken only between items.
// Reset: a clearing pass writes zero to all NUM_OPCODES*NUM_OPCODES entries
//   (16384 entries by default) before the first request is accepted.
`default_nettype none
`include "opcode_pair_frequency_counter_core_assert.svh"

module opcode_pair_frequency_counter_core #(
  parameter int unsigned NUM_OPCODES = opfc_pkg::NUM_OPCODES_DEF,
  parameter int unsigned COUNT_WIDTH = opfc_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned MAX_ROWS    = opfc_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [6:0] opcode, [13:7] rows, [15:14] zero
  input  logic [opfc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] mode
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] pair_count, [38:32] first_opcode, [45:39] second_opcode, [47:46] zero
  output logic [opfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] found
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import opfc_pkg::*;

  localparam int unsigned OPW       = $clog2(NUM_OPCODES);
  localparam int unsigned DEPTH     = NUM_OPCODES * NUM_OPCODES;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned RW        = $clog2(MAX_ROWS + 1);
  localparam int unsigned CW        = COUNT_WIDTH;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [OPW-1:0] LAST_OP  = OPW'(NUM_OPCODES - 1);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_LOG_WR   = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_SCAN_END = 3'd4;
  localparam logic [2:0] S_EMIT     = 3'd5;

  logic [2:0]     state_q, state_d;
  logic [OPW-1:0] prev_q, prev_d;
  logic           has_prev_q, has_prev_d;
  logic [AW-1:0]  log_addr_q, log_addr_d;
  logic [RW-1:0]  rows_left_q, rows_left_d;
  logic [AW-1:0]  scan_addr_q, scan_addr_d;
  logic [OPW-1:0] row_q, row_d, col_q, col_d;
  logic           rd_en_q, rd_en_d;
  logic [OPW-1:0] rd_row_q, rd_col_q;
  logic [AW-1:0]  rd_addr_q;

  logic           out_valid_q, out_valid_d, out_load;
  logic [OUT_COUNT_W-1:0] out_count_q;
  logic [OPCODE_W-1:0]    out_first_q, out_second_q;
  logic           out_found_q, out_last_q;
  logic           out_found_d, out_last_d;

  logic [OPCODE_W-1:0] in_op;
  logic [ROWS_W-1:0]   in_rows;
  logic                in_mode, accept, op_ok, out_free, scan_start;
  logic [RW-1:0]       rows_eff;
  logic [AW-1:0]       log_addr_calc;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [CW-1:0] mem_wdata, mem_rdata;

  logic [CW-1:0]          best_count;
  logic [OPW-1:0]         best_row, best_col;
  logic [AW-1:0]          best_addr;
  opfc_scan_stat_t        scan_stat;
  logic [OUT_COUNT_W-1:0] best_count_sat;

  assign in_op   = s_axis_tdata[OPCODE_W-1:0];
  assign in_rows = s_axis_tdata[OPCODE_W+ROWS_W-1:OPCODE_W];
  assign in_mode = s_axis_tuser;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op_ok         = (32'(in_op) < NUM_OPCODES);
  assign rows_eff      = (32'(in_rows) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(in_rows);
  assign log_addr_calc = AW'(AW'(prev_q) * AW'(NUM_OPCODES)) + AW'(in_op);
  assign out_free      = !out_valid_q || m_axis_tready;

  if (CW > OUT_COUNT_W) begin : g_count_sat
    assign best_count_sat = (|best_count[CW-1:OUT_COUNT_W]) ? '1
                                                            : best_count[OUT_COUNT_W-1:0];
  end else begin : g_count_ext
    assign best_count_sat = OUT_COUNT_W'(best_count);
  end

  always_comb begin
    state_d     = state_q;
    prev_d      = prev_q;
    has_prev_d  = has_prev_q;
    log_addr_d  = log_addr_q;
    rows_left_d = rows_left_q;
    scan_addr_d = scan_addr_q;
    row_d       = row_q;
    col_d       = col_q;
    rd_en_d     = 1'b0;
    scan_start  = 1'b0;
    out_load    = 1'b0;
    out_found_d = 1'b0;
    out_last_d  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = scan_addr_q;
    mem_wdata   = '0;
    mem_raddr   = scan_addr_q;

    unique case (state_q)
      S_CLEAR: begin
        mem_we      = 1'b1;
        scan_addr_d = scan_addr_q + 1'b1;
        if (scan_addr_q == LAST_ADDR) begin
          scan_addr_d = '0;
          state_d     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (!in_mode) begin
            if (op_ok) begin
              prev_d     = OPW'(in_op);
              has_prev_d = 1'b1;
              if (has_prev_q) begin
                mem_raddr  = log_addr_calc;
                log_addr_d = log_addr_calc;
                state_d    = S_LOG_WR;
              end
            end
          end else if (rows_eff != '0) begin
            rows_left_d = rows_eff;
            scan_start  = 1'b1;
            scan_addr_d = '0;
            row_d       = '0;
            col_d       = '0;
            state_d     = S_SCAN;
          end
        end
      end
      S_LOG_WR: begin
        // saturating increment of the counter read last cycle
        mem_we    = 1'b1;
        mem_waddr = log_addr_q;
        mem_wdata = (mem_rdata == '1) ? mem_rdata : CW'(mem_rdata + 1'b1);
        state_d   = S_IDLE;
      end
      S_SCAN: begin
        rd_en_d     = 1'b1;
        scan_addr_d = scan_addr_q + 1'b1;
        if (col_q == LAST_OP) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
        if (scan_addr_q == LAST_ADDR) begin
          scan_addr_d = '0;
          row_d       = '0;
          col_d       = '0;
          state_d     = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        // last entry goes through the compare at this edge
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!scan_stat.found) begin
            out_found_d = 1'b0;
            out_last_d  = 1'b1;
            state_d     = S_IDLE;
          end else begin
            // last when the request is used up or no other nonzero counter is left
            out_found_d = 1'b1;
            out_last_d  = (rows_left_q == RW'(1)) || !scan_stat.multi;
            mem_we      = 1'b1;
            mem_waddr   = best_addr;
            mem_wdata   = '0;
            if (out_last_d) begin
              state_d = S_IDLE;
            end else begin
              rows_left_d = rows_left_q - 1'b1;
              scan_start  = 1'b1;
              state_d     = S_SCAN;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      prev_q      <= '0;
      has_prev_q  <= 1'b0;
      rows_left_q <= '0;
      scan_addr_q <= '0;
      row_q       <= '0;
      col_q       <= '0;
      rd_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      has_prev_q  <= has_prev_d;
      rows_left_q <= rows_left_d;
      scan_addr_q <= scan_addr_d;
      row_q       <= row_d;
      col_q       <= col_d;
      rd_en_q     <= rd_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    log_addr_q <= log_addr_d;
    rd_row_q   <= row_q;
    rd_col_q   <= col_q;
    rd_addr_q  <= scan_addr_q;
    if (out_load) begin
      out_count_q  <= out_found_d ? best_count_sat : '0;
      out_first_q  <= out_found_d ? OPCODE_W'(best_row) : '0;
      out_second_q <= out_found_d ? OPCODE_W'(best_col) : '0;
      out_found_q  <= out_found_d;
      out_last_q   <= out_last_d;
    end
  end

  opfc_table #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (CW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  opfc_maxscan #(
    .CW  (CW),
    .OPW (OPW),
    .AW  (AW)
  ) u_maxscan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (scan_start),
    .en_i         (rd_en_q),
    .data_i       (mem_rdata),
    .row_i        (rd_row_q),
    .col_i        (rd_col_q),
    .addr_i       (rd_addr_q),
    .best_count_o (best_count),
    .best_row_o   (best_row),
    .best_col_o   (best_col),
    .best_addr_o  (best_addr),
    .stat_o       (scan_stat)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_COUNT_W - 2 * OPCODE_W){1'b0}},
                          out_second_q, out_first_q, out_count_q};
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tlast  = out_last_q;

  `OPFC_ASSERT_IMPLY(a_found_count_nonzero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:0] != '0, "found request carries a zero count")
  `OPFC_ASSERT_IMPLY(a_not_found_is_last, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tlast, "not-found request without last")
  `OPFC_ASSERT_IMPLY(a_scan_has_rows, clk_i, rst_ni, state_q == S_SCAN, (rows_left_q != '0) && (32'(rows_left_q) <= MAX_ROWS), "scan running with bad row budget")
  `OPFC_ASSERT_IMPLY(a_last_returns_idle, clk_i, rst_ni, out_load && out_last_d, ##1 (state_q == S_IDLE), "report did not end after last request")

endmodule

`default_nettype wire

// ===== sim/opfc_tb_pkg.sv =====
// Testbench types for the opcode pair frequency counter: request modes and
// the layout of one report row. Depends on nothing.
`default_nettype none

package opfc_tb_pkg;

  typedef enum logic {
    MODE_LOG    = 1'b0,
    MODE_REPORT = 1'b1
  } opfc_mode_e;

  typedef struct packed {
    logic [31:0] pair_count;
    logic [6:0]  first_opcode;
    logic [6:0]  second_opcode;
    logic        found;
    logic        last;
  } pair_row_t;

endpackage

`default_nettype wire

// ===== sim/opfc_stream_checker.sv =====
// Stream checker: keeps a shadow pair histogram, ranks the top pairs on each
// report request and compares every result row. Depends on opfc_pkg, opfc_tb_pkg.
`default_nettype none

module opfc_stream_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [opfc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [opfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tuser,
  input  logic                            m_axis_tlast,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              live_pairs_o
);
  import opfc_tb_pkg::*;

  localparam int unsigned NUM_OPCODES = opfc_pkg::NUM_OPCODES_DEF;
  localparam int unsigned NUM_PAIRS   = NUM_OPCODES * NUM_OPCODES;
  localparam int unsigned MAX_ROWS    = opfc_pkg::MAX_ROWS_DEF;
  localparam int unsigned OPW         = opfc_pkg::OPCODE_W;
  localparam int unsigned FIRST_LSB   = opfc_pkg::OUT_COUNT_W;
  localparam int unsigned SECOND_LSB  = opfc_pkg::OUT_COUNT_W + opfc_pkg::OPCODE_W;

  logic [opfc_pkg::COUNT_WIDTH_DEF-1:0] pair_hist [NUM_PAIRS];
  logic [OPW-1:0] prev_opcode;
  logic           have_prev;
  int             live_pairs;   // nonzero counters in the shadow table
  int             fail_count = 0;
  pair_row_t      pending_rows [$];
  pair_row_t      want_row;

  task automatic tally_opcode(input logic [OPW-1:0] opcode);
    int unsigned idx;
    idx = prev_opcode * NUM_OPCODES + opcode;
    if (have_prev) begin
      if (pair_hist[idx] == '0) live_pairs++;
      if (pair_hist[idx] != '1) pair_hist[idx] = pair_hist[idx] + 1'b1;
    end
    prev_opcode = opcode;
    have_prev   = 1'b1;
  endtask

  // Repeated max search; strict compare keeps the lowest index on ties.
  task automatic rank_top_pairs(input logic [6:0] rows_req);
    int unsigned wanted, emitted, best_idx;
    logic [opfc_pkg::COUNT_WIDTH_DEF-1:0] best;
    logic empty;
    pair_row_t row;
    wanted  = (rows_req > MAX_ROWS) ? MAX_ROWS : rows_req;
    emitted = 0;
    empty   = 1'b0;
    while (emitted < wanted && !empty) begin
      best     = '0;
      best_idx = 0;
      for (int i = 0; i < NUM_PAIRS; i++) begin
        if (pair_hist[i] > best) begin
          best     = pair_hist[i];
          best_idx = i;
        end
      end
      if (best == '0) begin
        empty = 1'b1;
        if (emitted == 0) begin
          row      = '0;
          row.last = 1'b1;
          pending_rows.push_back(row);
        end
      end else begin
        row.pair_count    = best;
        row.first_opcode  = OPW'(best_idx / NUM_OPCODES);
        row.second_opcode = OPW'(best_idx % NUM_OPCODES);
        row.found         = 1'b1;
        row.last          = 1'b0;
        pending_rows.push_back(row);
        pair_hist[best_idx] = '0;
        live_pairs--;
        emitted++;
      end
    end
    if (emitted > 0) begin
      row      = pending_rows.pop_back();
      row.last = 1'b1;
      pending_rows.push_back(row);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PAIRS; i++) pair_hist[i] = '0;
      prev_opcode = '0;
      have_prev   = 1'b0;
      live_pairs  = 0;
      pending_rows.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == MODE_REPORT) rank_top_pairs(s_axis_tdata[13:7]);
        else tally_opcode(s_axis_tdata[6:0]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_rows.size() == 0) begin
          $error("result row with none expected: count %0d pair (%0d,%0d)",
                 m_axis_tdata[31:0], m_axis_tdata[FIRST_LSB +: OPW],
                 m_axis_tdata[SECOND_LSB +: OPW]);
          fail_count++;
        end else begin
          want_row = pending_rows.pop_front();
          check_field("pair_count", want_row.pair_count, m_axis_tdata[31:0]);
          check_field("first_opcode", want_row.first_opcode, m_axis_tdata[FIRST_LSB +: OPW]);
          check_field("second_opcode", want_row.second_opcode,
                      m_axis_tdata[SECOND_LSB +: OPW]);
          check_field("found", want_row.found, m_axis_tuser);
          check_field("last", want_row.last, m_axis_tlast);
        end
      end
    end
    pending_o    <= pending_rows.size();
    live_pairs_o <= live_pairs;
    fail_count_o <= fail_count;
  end

endmodule

`default_nettype wire

// ===== sim/tb_opcode_pair_frequency_counter_core.sv =====
// Testbench top for opcode_pair_frequency_counter_core: clock, reset, request
// stimulus, result back-pressure and verdict. Depends on opfc_stream_checker.
`default_nettype none

module tb_opcode_pair_frequency_counter_core;
  import opfc_tb_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 50000;    // long sink stall right after reset
  localparam int unsigned DRAIN_CYCLES = 20000;    // more than one full table scan
  localparam int unsigned LIMIT_CYCLES = 12000000;
  localparam int unsigned RANDOM_ITEMS = 385;
  localparam int unsigned MIN_REPORTS  = 24;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [opfc_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // [6:0] opcode, [13:7] rows, [15:14] zero
  logic                            s_axis_tuser;   // [0] mode
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [opfc_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // [31:0] count, [38:32] first, [45:39] second
  logic                            m_axis_tuser;   // [0] found
  logic                            m_axis_tlast;

  int          fail_count;
  int          pending;
  int          live_pairs;
  bit          calm = 1'b0;
  int unsigned cycle_count = 0;

  opcode_pair_frequency_counter_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  opfc_stream_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .live_pairs_o  (live_pairs)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAIL opcode_pair_frequency_counter_core");
      $finish;
    end
  end

  // Result sink: random stall per row, with runs of no stall.
  initial begin : result_sink
    int unsigned idle;
    int unsigned calm_left;
    calm_left     = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    repeat (HOLD_CYCLES) @(negedge clk_i);
    forever begin
      if (calm_left > 0) begin
        idle = 0;
        calm_left--;
      end else begin
        idle = $urandom_range(0, 5);
        if ($urandom_range(0, 7) == 0) calm_left = $urandom_range(4, 16);
      end
      if (idle > 0) begin
        m_axis_tready <= 1'b0;
        repeat (idle) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk_i);
    end
  end

  // Returns at the falling edge after the request is taken, valid still high.
  task automatic offer(input opfc_mode_e mode, input logic [6:0] opcode,
                       input logic [6:0] rows);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {2'b00, rows, opcode};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
  endtask

  task automatic log_opcode(input logic [6:0] opcode);
    offer(MODE_LOG, opcode, 7'($urandom));
  endtask

  task automatic request_report(input logic [6:0] rows);
    offer(MODE_REPORT, 7'($urandom), rows);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned items;
    int unsigned reports;
    int unsigned burst;
    int unsigned pick;
    logic [6:0]  rows;
    logic [6:0]  alpha [3];
    items         = 0;
    reports       = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty table: zero rows gives nothing, one row gives a not-found row.
    // The sink is still stalled; logs need no output, so the next report backs up the input.
    request_report(7'd0);
    request_report(7'd1);
    log_opcode(7'd0);       // no predecessor yet
    log_opcode(7'd127);
    log_opcode(7'd127);
    log_opcode(7'd0);
    log_opcode(7'd0);
    log_opcode(7'd127);
    log_opcode(7'd0);
    // Ties at count 2 and count 1: lowest index first
    request_report(7'd2);
    request_report(7'd0);
    log_opcode(7'h55);
    log_opcode(7'h2a);
    // Oversized row count with few live pairs: saturates, then stops early
    request_report(7'd127);
    log_opcode(7'h2a);
    request_report(7'd64);
    request_report(7'd1);
    wait_for_results();

    while (items < RANDOM_ITEMS || reports < MIN_REPORTS) begin
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 3; k++) alpha[k] = 7'($urandom);
      burst = $urandom_range(0, 30);
      repeat (burst) begin
        if ($urandom_range(0, 7) == 0) log_opcode(7'($urandom));
        else log_opcode(alpha[$urandom_range(0, 2)]);
        items++;
      end
      // A report costs a full table scan per row, so rows stay small
      // unless the table is nearly empty.
      pick = $urandom_range(0, 19);
      if (live_pairs <= 1 && $urandom_range(0, 3) == 0) rows = 7'($urandom_range(64, 127));
      else if (pick < 2) rows = 7'd0;
      else if (pick < 12) rows = 7'd1;
      else if (pick < 18) rows = 7'd2;
      else rows = 7'd3;
      request_report(rows);
      items++;
      if (rows != 7'd0) reports++;
      if ($urandom_range(0, 7) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS opcode_pair_frequency_counter_core");
    end else begin
      $display("FAIL opcode_pair_frequency_counter_core");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/opfc_pkg.sv
sv/opfc_table.sv
sv/opfc_maxscan.sv
sv/opcode_pair_frequency_counter_core.sv
sim/opfc_tb_pkg.sv
sim/opfc_stream_checker.sv
sim/tb_opcode_pair_frequency_counter_core.sv
